// File: design/uv_sphere_mesh_generator_top_defines.svh
// Assertion macros shared by the checker files.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef UV_SPHERE_MESH_GENERATOR_TOP_DEFINES_SVH
`define UV_SPHERE_MESH_GENERATOR_TOP_DEFINES_SVH
// Check a property while out of reset.
`define USG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property at every edge, reset included.
`define USG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: design/usg_pkg.sv
// Shared types, constants and helpers for the sphere mesh generator.
// Depends on nothing.
`default_nettype none
package usg_pkg;
  localparam int MAX_SEGMENTS = 256;
  localparam int ANGLE_BITS   = 16;
  localparam int COORD_BITS   = 17;
  localparam int CORDIC_STEPS = 28;
  localparam int CW           = 34;
  localparam int QDEPTH       = 4;
  localparam int QAW          = 2;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_SEGS   = 2'd1;
  localparam logic [1:0] REG_SMOOTH = 2'd2;

  localparam logic signed [CW-1:0] CORDIC_X0 = CW'(652032874);
  localparam logic signed [32:0] COORD_LIM = 33'((1 << (COORD_BITS - 1)) - 1);

  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic [14:0] corner_a;
    logic [14:0] corner_b;
    logic [14:0] corner_c;
    logic        edge_ab;
    logic        edge_bc;
    logic        edge_ca;
    logic        smooth;
    logic        err;
  } res_t;

  typedef struct packed {
    logic                  cordic;
    logic [ANGLE_BITS-1:0] ang_p;
    logic [ANGLE_BITS-1:0] ang_t;
    logic [15:0]           radius;
    res_t                  res;
  } req_t;

  // Q30 product, round half up.
  function automatic logic signed [32:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    p = p + 64'sd536870912;
    return 33'(p >>> 30);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [32:0] v);
    logic signed [32:0] w;
    if (v > COORD_LIM) w = COORD_LIM;
    else if (v < -COORD_LIM) w = -COORD_LIM;
    else w = v;
    return w[COORD_BITS-1:0];
  endfunction
endpackage
`default_nettype wire

// File: design/usg_front.sv
// Front end: configuration registers and request classification.
// Depends on usg_pkg.
`default_nettype none
module usg_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_wdata,
  input  wire logic              action,
  input  wire logic [7:0]        ring,
  input  wire logic [7:0]        position,
  input  wire logic              half,
  output usg_pkg::req_t          req
);
  logic [15:0] rad_r;
  logic [8:0]  seg_r;
  logic        smo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r <= 16'd256;
      seg_r <= 9'd8;
      smo_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        usg_pkg::REG_RADIUS: rad_r <= cfg_wdata;
        usg_pkg::REG_SEGS:   seg_r <= cfg_wdata[8:0];
        usg_pkg::REG_SMOOTH: smo_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Step tables: theta step by segs-1, phi step by bands.
  logic [16:0] ts_tab [256];
  logic [16:0] ps_tab [256];
  for (genvar g = 0; g < 256; g++) begin : g_tab
    localparam logic [16:0] TS = 17'((65536 + (g + 1) / 2) / (g + 1));
    localparam logic [16:0] PS = (g == 0) ? 17'd0 :
                                 17'((65536 + g) / (2 * ((g == 0) ? 1 : g)));
    assign ts_tab[g] = TS;
    assign ps_tab[g] = PS;
  end

  logic [7:0]  bands;
  logic        err;
  logic [24:0] prod_p, prod_t;
  logic [16:0] m1, m0, top, bot, pe, ne;
  logic [8:0]  pos1, nxt;
  logic [7:0]  tix;

  always_comb begin
    bands  = seg_r[8:1];
    err    = (seg_r < 9'd4) || (seg_r > 9'(usg_pkg::MAX_SEGMENTS)) ||
             ({1'b0, position} >= seg_r) ||
             (action ? (ring >= bands) : (ring > bands));
    tix    = seg_r[7:0] - 8'd1;
    prod_p = ring * ps_tab[bands];
    prod_t = position * ts_tab[tix];
    m1     = ring * seg_r;
    m0     = m1 - 17'(seg_r);
    top    = m0 + 17'd1;
    bot    = m1 + 17'd1;
    pos1   = {1'b0, position} + 9'd1;
    nxt    = (pos1 == seg_r) ? 9'd0 : pos1;
    pe     = 17'(position);
    ne     = 17'(nxt);

    req        = '0;
    req.radius = rad_r;
    req.ang_p  = prod_p[usg_pkg::ANGLE_BITS-1:0];
    req.ang_t  = prod_t[usg_pkg::ANGLE_BITS-1:0];
    if (err) begin
      req.res.err = 1'b1;
    end else if (!action) begin
      if (ring == 8'd0) begin
        req.res.coord_z = {1'b0, rad_r};
      end else if (ring == bands) begin
        req.res.coord_z = -{1'b0, rad_r};
      end else begin
        req.cordic = 1'b1;
      end
    end else begin
      req.res.smooth = smo_r;
      if (ring == 8'd0) begin
        req.res.corner_a = 15'(pos1);
        req.res.corner_b = 15'(ne + 17'd1);
        req.res.edge_ab  = 1'b1;
        req.res.edge_bc  = 1'b1;
        req.res.edge_ca  = 1'b1;
      end else if (ring == bands - 8'd1) begin
        req.res.corner_a = 15'(pe + top);
        req.res.corner_b = bot[14:0];
        req.res.corner_c = 15'(ne + top);
        req.res.edge_ab  = 1'b1;
        req.res.edge_bc  = 1'b1;
        req.res.edge_ca  = 1'b1;
      end else if (!half) begin
        req.res.corner_a = 15'(pe + bot);
        req.res.corner_b = 15'(ne + bot);
        req.res.corner_c = 15'(pe + top);
        req.res.edge_ab  = 1'b1;
        req.res.edge_ca  = 1'b1;
      end else begin
        req.res.corner_a = 15'(ne + bot);
        req.res.corner_b = 15'(ne + top);
        req.res.corner_c = 15'(pe + top);
        req.res.edge_ab  = 1'b1;
        req.res.edge_bc  = 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// File: design/usg_queue.sv
// Short request queue between front end and back end.
// Depends on usg_pkg.
`default_nettype none
module usg_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  usg_pkg::req_t      wr_data,
  output logic               not_full,
  input  wire logic          pop,
  output logic               not_empty,
  output usg_pkg::req_t      rd_data
);
  usg_pkg::req_t                 mem_r [usg_pkg::QDEPTH];
  logic [usg_pkg::QAW-1:0]       wp_r, rp_r;
  logic [usg_pkg::QAW:0]         cnt_r;

  assign not_full  = cnt_r != (usg_pkg::QAW+1)'(usg_pkg::QDEPTH);
  assign not_empty = cnt_r != '0;
  assign rd_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (usg_pkg::QAW+1)'(push) - (usg_pkg::QAW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// File: design/usg_back.sv
// Back end: two CORDIC pipelines, Q30 products, saturation and output register.
// Depends on usg_pkg.
`default_nettype none
module usg_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  usg_pkg::req_t      q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output usg_pkg::res_t      out_res
);
  localparam int N = usg_pkg::CORDIC_STEPS;
  localparam int CW = usg_pkg::CW;

  logic en;
  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_valid;

  logic signed [CW-1:0] xp_r [N+1];
  logic signed [CW-1:0] yp_r [N+1];
  logic signed [CW-1:0] zp_r [N+1];
  logic signed [CW-1:0] xt_r [N+1];
  logic signed [CW-1:0] yt_r [N+1];
  logic signed [CW-1:0] zt_r [N+1];
  logic                 fp_r [N+1];
  logic                 ft_r [N+1];
  logic                 vld_r [N+1];
  usg_pkg::req_t        itm_r [N+1];

  // Fold angle into [-1/4,1/4) turn.
  logic [31:0] ap, at, ap2, at2, sp_tmp, st_tmp;
  logic        fpn, ftn;
  always_comb begin
    ap     = {q_data.ang_p, 16'h0000};
    at     = {q_data.ang_t, 16'h0000};
    sp_tmp = ap + 32'h40000000;
    st_tmp = at + 32'h40000000;
    fpn    = sp_tmp[31];
    ftn    = st_tmp[31];
    ap2    = fpn ? (ap ^ 32'h80000000) : ap;
    at2    = ftn ? (at ^ 32'h80000000) : at;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp_r[0]  <= usg_pkg::CORDIC_X0;
      yp_r[0]  <= '0;
      zp_r[0]  <= CW'(signed'(ap2));
      xt_r[0]  <= usg_pkg::CORDIC_X0;
      yt_r[0]  <= '0;
      zt_r[0]  <= CW'(signed'(at2));
      fp_r[0]  <= fpn;
      ft_r[0]  <= ftn;
      itm_r[0] <= q_data;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [CW-1:0] ATN = CW'(usg_pkg::ATAN_TURN[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zp_r[i][CW-1]) begin
          xp_r[i+1] <= xp_r[i] - (yp_r[i] >>> i);
          yp_r[i+1] <= yp_r[i] + (xp_r[i] >>> i);
          zp_r[i+1] <= zp_r[i] - ATN;
        end else begin
          xp_r[i+1] <= xp_r[i] + (yp_r[i] >>> i);
          yp_r[i+1] <= yp_r[i] - (xp_r[i] >>> i);
          zp_r[i+1] <= zp_r[i] + ATN;
        end
        if (!zt_r[i][CW-1]) begin
          xt_r[i+1] <= xt_r[i] - (yt_r[i] >>> i);
          yt_r[i+1] <= yt_r[i] + (xt_r[i] >>> i);
          zt_r[i+1] <= zt_r[i] - ATN;
        end else begin
          xt_r[i+1] <= xt_r[i] + (yt_r[i] >>> i);
          yt_r[i+1] <= yt_r[i] - (xt_r[i] >>> i);
          zt_r[i+1] <= zt_r[i] + ATN;
        end
        fp_r[i+1]  <= fp_r[i];
        ft_r[i+1]  <= ft_r[i];
        itm_r[i+1] <= itm_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= q_valid;
      for (int k = 0; k < N; k++) vld_r[k+1] <= vld_r[k];
    end
  end

  // Unfold, then first product stage.
  logic signed [31:0] sp, cp, st, ct, rr;
  always_comb begin
    sp = 32'(fp_r[N] ? -yp_r[N] : yp_r[N]);
    cp = 32'(fp_r[N] ? -xp_r[N] : xp_r[N]);
    st = 32'(ft_r[N] ? -yt_r[N] : yt_r[N]);
    ct = 32'(ft_r[N] ? -xt_r[N] : xt_r[N]);
    rr = signed'({16'h0000, itm_r[N].radius});
  end

  logic signed [32:0] sxc_r, sxs_r, zc_r, x2_r, y2_r, z2_r;
  logic               v1_r, v2_r;
  usg_pkg::req_t      i1_r, i2_r;
  logic               out_valid_r;
  usg_pkg::res_t      out_res_r;
  usg_pkg::res_t      out_res_nxt;

  // Take the classified result and fill in saturated coordinates for CORDIC vertices.
  always_comb begin
    out_res_nxt = i2_r.res;
    if (i2_r.cordic) begin
      out_res_nxt.coord_x = usg_pkg::sat(x2_r);
      out_res_nxt.coord_y = usg_pkg::sat(y2_r);
      out_res_nxt.coord_z = usg_pkg::sat(z2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sxc_r <= usg_pkg::mul_q30(sp, ct);
      sxs_r <= usg_pkg::mul_q30(sp, st);
      zc_r  <= usg_pkg::mul_q30(rr, cp);
      i1_r  <= itm_r[N];
      x2_r  <= usg_pkg::mul_q30(signed'({16'h0000, i1_r.radius}), 32'(sxc_r));
      y2_r  <= usg_pkg::mul_q30(signed'({16'h0000, i1_r.radius}), 32'(sxs_r));
      z2_r  <= zc_r;
      i2_r  <= i1_r;
      out_res_r <= out_res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= vld_r[N];
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
endmodule
`default_nettype wire

// File: design/uv_sphere_mesh_generator_top.sv
// Throughput: one request per cycle while the output is not stalled; the CORDIC pipelines
// take a new angle pair each cycle unless the output stalls them.
// The four-entry queue keeps the input accepting for up to four requests while the output stalls.
// Reset: synchronous active-low rst_n clears the queue, pipeline valids and
// restores radius 256, 8 segments, smoothing off.
// Depends on usg_pkg, usg_front, usg_queue, usg_back.
`default_nettype none
module uv_sphere_mesh_generator_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [23:0]  in_tdata,   // ring[7:0], position[15:8], half[16], zero pad
  input  wire logic         in_tuser,   // action (0 vertex, 1 face)
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // coord_x[16:0] coord_y[33:17] coord_z[50:34] corner_a[65:51] corner_b[80:66]
  // corner_c[95:81] edge_ab[96] edge_bc[97] edge_ca[98] smooth_group[99]
  // range_error[100], zero pad
  output logic [103:0]      out_tdata
);
  usg_pkg::req_t req, q_head;
  usg_pkg::res_t res;
  logic q_not_full, q_not_empty, q_pop, push;

  // Classify the request and hold configuration.
  usg_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .action(in_tuser), .ring(in_tdata[7:0]), .position(in_tdata[15:8]),
    .half(in_tdata[16]), .req
  );

  assign in_tready = q_not_full;
  assign push      = in_tvalid && q_not_full;

  // Decouple the front end from the back-end stall.
  usg_queue u_queue (
    .clk, .rst_n, .push, .wr_data(req), .not_full(q_not_full),
    .pop(q_pop), .not_empty(q_not_empty), .rd_data(q_head)
  );

  // Trigonometry, scaling and the output register.
  usg_back u_back (
    .clk, .rst_n, .q_valid(q_not_empty), .q_data(q_head), .q_pop,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {3'b000, res.err, res.smooth, res.edge_ca, res.edge_bc,
                      res.edge_ab, res.corner_c, res.corner_b, res.corner_a,
                      res.coord_z, res.coord_y, res.coord_x};
endmodule
`default_nettype wire

// File: design/usg_checker.sv
// Port-level checks for the sphere mesh generator, bound to the top level.
// Depends on uv_sphere_mesh_generator_top_defines.svh.
`default_nettype none
`include "uv_sphere_mesh_generator_top_defines.svh"
module usg_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [103:0] out_tdata
);
  `USG_ASSERT(a_hold_valid, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `USG_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result after reset")
  `USG_ASSERT(a_err_clean, out_tvalid && out_tdata[100] |-> out_tdata[99:0] == 100'd0, "error result not clean")
  `USG_ASSERT(a_face_nocoord, out_tvalid && out_tdata[96] |-> out_tdata[50:0] == 51'd0, "face with coordinates")
endmodule

bind uv_sphere_mesh_generator_top usg_checker u_usg_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);
`default_nettype wire

// File: sim/uv_sphere_mesh_generator_top_test.sv
// Self-checking testbench for the sphere mesh generator: vertex and face requests
// are predicted with a local CORDIC model and checked against each result.
// Depends on usg_pkg and uv_sphere_mesh_generator_top.
`default_nettype none
module uv_sphere_mesh_generator_top_test;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 45;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [23:0]  in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;

  uv_sphere_mesh_generator_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Local copy of the register file.
  logic [15:0] radius_q;
  logic [8:0]  segs_q;
  logic        smooth_q;

  usg_pkg::res_t mesh_results[$];
  int   mismatches;
  int   cycles;
  int   sent_count;
  int   checked_count;
  int   send_idle_pct;
  int   recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 mesh_results.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: stall at random according to the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Floor shift: arithmetic shift on a signed value already rounds down.
  function automatic void turn_sincos(input logic [15:0] angle,
                                      output longint sn, output longint cs);
    logic [31:0] a;
    logic [31:0] probe;
    logic        flip;
    longint      x, y, z, nx;
    a = {angle, 16'h0000};
    probe = a + 32'h40000000;
    flip = probe[31];
    if (flip) a = a ^ 32'h80000000;
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < usg_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(usg_pkg::ATAN_TURN[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(usg_pkg::ATAN_TURN[i]);
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic longint q30_product(input longint a, input longint b);
    return (a * b + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic logic [usg_pkg::COORD_BITS-1:0] clamp_coord(input longint v);
    longint lim;
    lim = (longint'(1) << (usg_pkg::COORD_BITS - 1)) - 1;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[usg_pkg::COORD_BITS-1:0];
  endfunction

  // Work out the result of one request under the current register values.
  function automatic usg_pkg::res_t predict_mesh_element(input logic act,
                                                         input logic [7:0] ring,
                                                         input logic [7:0] pos,
                                                         input logic hf);
    usg_pkg::res_t r;
    int     segs, bands, nxt, lo, top, bot;
    int     a, b, c;
    int     pstep, tstep;
    longint sp, cp, st, ct, rad;
    r = '0;
    segs = segs_q;
    bands = segs / 2;
    rad = radius_q;
    if (segs < 4 || segs > usg_pkg::MAX_SEGMENTS || pos >= segs ||
        (act == 1'b0 ? ring > bands : ring >= bands)) begin
      r.err = 1'b1;
      return r;
    end
    if (act == 1'b0) begin
      if (ring == 0) begin
        r.coord_z = clamp_coord(rad);
      end else if (ring == bands) begin
        r.coord_z = clamp_coord(-rad);
      end else begin
        pstep = (65536 + bands) / (2 * bands);
        tstep = (65536 + segs / 2) / segs;
        turn_sincos(16'(ring * pstep), sp, cp);
        turn_sincos(16'(pos * tstep), st, ct);
        r.coord_x = clamp_coord(q30_product(rad, q30_product(sp, ct)));
        r.coord_y = clamp_coord(q30_product(rad, q30_product(sp, st)));
        r.coord_z = clamp_coord(q30_product(rad, cp));
      end
      return r;
    end
    nxt = (pos + 1) % segs;
    if (ring == 0) begin
      a = pos + 1; b = nxt + 1; c = 0;
      r.edge_ab = 1'b1; r.edge_bc = 1'b1; r.edge_ca = 1'b1;
    end else if (ring == bands - 1) begin
      lo = segs * (bands - 2) + 1;
      a = pos + lo; b = segs * (bands - 1) + 1; c = nxt + lo;
      r.edge_ab = 1'b1; r.edge_bc = 1'b1; r.edge_ca = 1'b1;
    end else begin
      top = (ring - 1) * segs + 1;
      bot = ring * segs + 1;
      if (!hf) begin
        a = pos + bot; b = nxt + bot; c = pos + top;
        r.edge_ab = 1'b1; r.edge_ca = 1'b1;
      end else begin
        a = nxt + bot; b = nxt + top; c = pos + top;
        r.edge_ab = 1'b1; r.edge_bc = 1'b1;
      end
    end
    r.corner_a = a[14:0];
    r.corner_b = b[14:0];
    r.corner_c = c[14:0];
    r.smooth = smooth_q;
    return r;
  endfunction

  // Checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    usg_pkg::res_t want;
    usg_pkg::res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.coord_x  = out_tdata[16:0];
      got.coord_y  = out_tdata[33:17];
      got.coord_z  = out_tdata[50:34];
      got.corner_a = out_tdata[65:51];
      got.corner_b = out_tdata[80:66];
      got.corner_c = out_tdata[95:81];
      got.edge_ab  = out_tdata[96];
      got.edge_bc  = out_tdata[97];
      got.edge_ca  = out_tdata[98];
      got.smooth   = out_tdata[99];
      got.err      = out_tdata[100];
      if (mesh_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = mesh_results.pop_front();
        checked_count++;
        // Field by field; the packed struct holds exactly these fields.
        if (got.coord_x !== want.coord_x || got.coord_y !== want.coord_y ||
            got.coord_z !== want.coord_z || got.corner_a !== want.corner_a ||
            got.corner_b !== want.corner_b || got.corner_c !== want.corner_c ||
            got.edge_ab !== want.edge_ab || got.edge_bc !== want.edge_bc ||
            got.edge_ca !== want.edge_ca || got.smooth !== want.smooth ||
            got.err !== want.err) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected xyz %0d %0d %0d abc %0d %0d %0d e %b%b%b s %b err %b",
                     checked_count, want.coord_x, want.coord_y, want.coord_z,
                     want.corner_a, want.corner_b, want.corner_c, want.edge_ab,
                     want.edge_bc, want.edge_ca, want.smooth, want.err);
            $display("result %0d: actual   xyz %0d %0d %0d abc %0d %0d %0d e %b%b%b s %b err %b",
                     checked_count, got.coord_x, got.coord_y, got.coord_z,
                     got.corner_a, got.corner_b, got.corner_c, got.edge_ab,
                     got.edge_bc, got.edge_ca, got.smooth, got.err);
          end
        end
      end
    end
  end

  // Send one request; predict its result on the accepting edge.
  task automatic send_request(input logic act, input logic [7:0] ring,
                              input logic [7:0] pos, input logic hf);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {7'b0, hf, pos, ring};
    do @(posedge clk); while (!in_tready);
    mesh_results.push_back(predict_mesh_element(act, ring, pos, hf));
    sent_count++;
  endtask

  // Drop valid, wait for every result, then let the pipeline settle.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (mesh_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      usg_pkg::REG_RADIUS: radius_q = value;
      usg_pkg::REG_SEGS:   segs_q   = value[8:0];
      usg_pkg::REG_SMOOTH: smooth_q = value[0];
      default: ;
    endcase
  endtask

  task automatic set_idle_phase(input int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
      default: begin send_idle_pct = 13; recv_stall_pct = 13; end
    endcase
  endtask

  // Poles, equator and extreme positions at reset settings, then full radius.
  task automatic test_vertices;
    set_idle_phase(0);
    send_request(1'b0, 8'd0, 8'd0, 1'b0);
    send_request(1'b0, 8'd4, 8'd7, 1'b1);
    send_request(1'b0, 8'd2, 8'd0, 1'b0);
    send_request(1'b0, 8'd1, 8'd3, 1'b0);
    send_request(1'b0, 8'd3, 8'd5, 1'b0);
    drain();
    write_reg(usg_pkg::REG_RADIUS, 16'hFFFF);
    send_request(1'b0, 8'd0, 8'd0, 1'b0);
    send_request(1'b0, 8'd4, 8'd0, 1'b0);
    send_request(1'b0, 8'd2, 8'd1, 1'b0);
    send_request(1'b0, 8'd1, 8'd6, 1'b0);
    drain();
  endtask

  // Top, middle (both halves, wrap) and bottom bands, with smoothing on.
  task automatic test_faces;
    write_reg(usg_pkg::REG_SMOOTH, 16'd1);
    send_request(1'b1, 8'd0, 8'd0, 1'b0);
    send_request(1'b1, 8'd0, 8'd7, 1'b1);
    send_request(1'b1, 8'd1, 8'd7, 1'b0);
    send_request(1'b1, 8'd2, 8'd7, 1'b1);
    send_request(1'b1, 8'd3, 8'd2, 1'b0);
    send_request(1'b1, 8'd3, 8'd7, 1'b1);
    drain();
  endtask

  // Ring and position outside the mesh, and segment counts outside the valid span.
  task automatic test_range_cases;
    send_request(1'b0, 8'd5, 8'd0, 1'b0);
    send_request(1'b1, 8'd4, 8'd0, 1'b0);
    send_request(1'b0, 8'd0, 8'd8, 1'b0);
    send_request(1'b1, 8'hFF, 8'hFF, 1'b1);
    drain();
    write_reg(usg_pkg::REG_SEGS, 16'd3);
    send_request(1'b0, 8'd0, 8'd0, 1'b0);
    send_request(1'b1, 8'd0, 8'd0, 1'b0);
    drain();
    write_reg(usg_pkg::REG_SEGS, 16'd257);
    send_request(1'b0, 8'd0, 8'd0, 1'b0);
    drain();
  endtask

  // Random requests over a sweep of settings; most stay inside the mesh.
  task automatic test_random;
    int seg_sweep[12] = '{4, 5, 256, 255, 8, 17, 12, 64, 100, 0, 511, 6};
    int segs, bands, pick;
    logic       act, hf;
    logic [7:0] ring, pos;
    for (int s = 0; s < 12; s++) begin
      write_reg(usg_pkg::REG_SEGS, 16'(seg_sweep[s]));
      pick = $urandom_range(3);
      write_reg(usg_pkg::REG_RADIUS,
                pick == 0 ? 16'd0 : pick == 1 ? 16'hFFFF : 16'($urandom));
      write_reg(usg_pkg::REG_SMOOTH, 16'(s % 2));
      set_idle_phase(s);
      segs = seg_sweep[s];
      bands = segs / 2;
      for (int i = 0; i < 140; i++) begin
        act = $urandom_range(1);
        hf  = $urandom_range(1);
        if ($urandom_range(9) == 0 || segs < 4 || segs > usg_pkg::MAX_SEGMENTS) begin
          ring = $urandom;
          pos  = $urandom;
        end else begin
          ring = $urandom_range(act ? bands - 1 : bands);
          pos  = $urandom_range(segs - 1);
        end
        // Hold a long stall-free stretch now and then.
        if (i == 70 && s % 4 != 0) set_idle_phase(0);
        send_request(act, ring, pos, hf);
      end
      drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = usg_pkg::REG_RADIUS;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    mismatches = 0;
    sent_count = 0;
    checked_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    radius_q = 16'd256;
    segs_q = 9'd8;
    smooth_q = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_vertices();
    test_faces();
    test_range_cases();
    test_random();

    $display("covered %0d requests, %0d results checked, segment counts 0..511, radius 0..65535",
             sent_count, checked_count);
    $display("vertex, face and out-of-range requests under four idle and stall patterns");
    if (mismatches == 0 && mesh_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, mesh_results.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
